FILE: sv/rk4pp_pkg.sv
// Package: types, constants and micro-program decoder of the RK4 predator-prey step block.
`default_nettype none
package rk4pp_pkg;

  localparam int FRAC_BITS_DEF = 24;

  // Configuration registers
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 31;
  localparam int REG_STEP       = 0;
  localparam int REG_BIRTH_SEX  = 1;
  localparam int REG_BIRTH_ASEX = 2;
  localparam int REG_DEATH_SEX  = 3;
  localparam int REG_DEATH_ASEX = 4;
  localparam int REG_GROWTH     = 5;
  localparam int REG_INVK_GOOD  = 6;
  localparam int REG_INVK_HARSH = 7;

  localparam logic [CFG_W-1:0] CFG_RST [NUM_REGS] = '{
    31'd50332, 31'd1677722, 31'd3355443, 31'd251658,
    31'd251658, 31'd2516582, 31'd16777216, 31'd55924053
  };

  // Scratch memory layout
  localparam int RAM_DEPTH = 32;
  localparam int ADDR_W    = 5;
  localparam logic [ADDR_W-1:0] A_P  = 5'd0;
  localparam logic [ADDR_W-1:0] A_PP = 5'd4;
  localparam logic [ADDR_W-1:0] A_K1 = 5'd8;
  localparam logic [ADDR_W-1:0] A_K2 = 5'd12;
  localparam logic [ADDR_W-1:0] A_K3 = 5'd16;
  localparam logic [ADDR_W-1:0] A_K4 = 5'd20;
  localparam logic [ADDR_W-1:0] A_T0 = 5'd24;
  localparam logic [ADDR_W-1:0] A_T1 = 5'd25;
  localparam logic [ADDR_W-1:0] A_T2 = 5'd26;

  // Program segments
  localparam int SEG_W = 4;
  localparam int OFF_W = 5;
  localparam logic [SEG_W-1:0] SEG_LOAD = 4'd0;
  localparam logic [SEG_W-1:0] SEG_D1   = 4'd1;
  localparam logic [SEG_W-1:0] SEG_S1   = 4'd2;
  localparam logic [SEG_W-1:0] SEG_D2   = 4'd3;
  localparam logic [SEG_W-1:0] SEG_S2   = 4'd4;
  localparam logic [SEG_W-1:0] SEG_D3   = 4'd5;
  localparam logic [SEG_W-1:0] SEG_S3   = 4'd6;
  localparam logic [SEG_W-1:0] SEG_D4   = 4'd7;
  localparam logic [SEG_W-1:0] SEG_F0   = 4'd8;
  localparam logic [SEG_W-1:0] SEG_F1   = 4'd9;
  localparam logic [SEG_W-1:0] SEG_F2   = 4'd10;
  localparam logic [SEG_W-1:0] SEG_F3   = 4'd11;
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_F3;

  localparam int ACC_W = 36;

  typedef enum logic [3:0] {
    OP_MULF, OP_MULH, OP_ADD, OP_SUB, OP_RSUB,
    OP_ACC0, OP_ACC1, OP_DIV, OP_LOAD, OP_UPD
  } op_e;

  typedef enum logic [3:0] {
    B_RAM, B_STEP, B_BS, B_BA, B_DS, B_DA, B_GROW, B_INVK, B_ONE, B_Q25, B_Q50
  } bsrc_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_EX, ST_DIV, ST_WB, ST_FIN
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [ADDR_W-1:0] a;
    bsrc_e            bsrc;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] d;
    logic [1:0]       pidx;
  } uop_t;

  typedef struct packed {
    logic ex_en;
    logic wb_en;
    op_e  op;
  } alu_ctrl_t;

  function automatic logic signed [31:0] sat32(logic signed [64:0] x);
    logic signed [31:0] r;
    if (x > 65'sd2147483647) r = 32'sh7fffffff;
    else if (x < -65'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic uop_t mk(op_e op, logic [ADDR_W-1:0] a, bsrc_e bs,
                              logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] d, logic [1:0] p);
    uop_t u;
    u.op = op; u.a = a; u.bsrc = bs; u.b = b; u.d = d; u.pidx = p;
    return u;
  endfunction

  // One derivative evaluation: v at vb..vb+3, result at db..db+3
  function automatic uop_t deriv_uop(logic [OFF_W-1:0] off, logic [ADDR_W-1:0] vb,
                                     logic [ADDR_W-1:0] db);
    uop_t u;
    unique case (off)
      5'd0:  u = mk(OP_MULF, vb + 5'd3, B_Q25,  A_T0, A_T0, 2'd0);
      5'd1:  u = mk(OP_MULF, vb + 5'd2, B_Q25,  A_T0, A_T1, 2'd0);
      5'd2:  u = mk(OP_ADD,  A_T0,      B_RAM,  A_T1, A_T0, 2'd0);
      5'd3:  u = mk(OP_MULF, vb,        B_BS,   A_T0, A_T1, 2'd0);
      5'd4:  u = mk(OP_MULF, A_T1,      B_RAM,  A_T0, A_T1, 2'd0);
      5'd5:  u = mk(OP_MULF, vb,        B_DS,   A_T0, A_T2, 2'd0);
      5'd6:  u = mk(OP_SUB,  A_T1,      B_RAM,  A_T2, db,   2'd0);
      5'd7:  u = mk(OP_MULF, vb + 5'd3, B_Q50,  A_T0, A_T0, 2'd0);
      5'd8:  u = mk(OP_MULF, vb + 5'd1, B_BA,   A_T0, A_T1, 2'd0);
      5'd9:  u = mk(OP_MULF, A_T1,      B_RAM,  A_T0, A_T1, 2'd0);
      5'd10: u = mk(OP_MULF, vb + 5'd1, B_DA,   A_T0, A_T2, 2'd0);
      5'd11: u = mk(OP_SUB,  A_T1,      B_RAM,  A_T2, db + 5'd1, 2'd0);
      5'd12: u = mk(OP_MULF, vb + 5'd2, B_GROW, A_T0, A_T0, 2'd0);
      5'd13: u = mk(OP_MULF, vb + 5'd2, B_INVK, A_T0, A_T1, 2'd0);
      5'd14: u = mk(OP_RSUB, A_T1,      B_ONE,  A_T0, A_T1, 2'd0);
      5'd15: u = mk(OP_MULF, A_T0,      B_RAM,  A_T1, A_T0, 2'd0);
      5'd16: u = mk(OP_MULF, vb,        B_Q25,  A_T0, A_T1, 2'd0);
      5'd17: u = mk(OP_MULF, vb + 5'd2, B_RAM,  A_T1, A_T1, 2'd0);
      5'd18: u = mk(OP_SUB,  A_T0,      B_RAM,  A_T1, db + 5'd2, 2'd0);
      5'd19: u = mk(OP_MULF, vb + 5'd3, B_GROW, A_T0, A_T0, 2'd0);
      5'd20: u = mk(OP_MULF, vb + 5'd3, B_INVK, A_T0, A_T1, 2'd0);
      5'd21: u = mk(OP_RSUB, A_T1,      B_ONE,  A_T0, A_T1, 2'd0);
      5'd22: u = mk(OP_MULF, A_T0,      B_RAM,  A_T1, A_T0, 2'd0);
      5'd23: u = mk(OP_MULF, vb + 5'd1, B_Q50,  A_T0, A_T1, 2'd0);
      5'd24: u = mk(OP_MULF, vb,        B_Q25,  A_T0, A_T2, 2'd0);
      5'd25: u = mk(OP_ADD,  A_T1,      B_RAM,  A_T2, A_T1, 2'd0);
      5'd26: u = mk(OP_MULF, vb + 5'd3, B_RAM,  A_T1, A_T1, 2'd0);
      5'd27: u = mk(OP_SUB,  A_T0,      B_RAM,  A_T1, db + 5'd3, 2'd0);
      default: u = mk(OP_LOAD, A_T2,    B_RAM,  A_T2, A_T2, 2'd0);
    endcase
    return u;
  endfunction

  // Intermediate point: pp = p + k*h (half or full)
  function automatic uop_t step_uop(logic [OFF_W-1:0] off, logic [ADDR_W-1:0] kb,
                                    logic half);
    uop_t u;
    logic [ADDR_W-1:0] i;
    i = {3'd0, off[2:1]};
    if (!off[0]) u = mk(half ? OP_MULH : OP_MULF, kb + i, B_STEP, A_T0, A_T0, 2'd0);
    else u = mk(OP_ADD, A_P + i, B_RAM, A_T0, A_PP + i, 2'd0);
    return u;
  endfunction

  // Final update of population i
  function automatic uop_t final_uop(logic [OFF_W-1:0] off, logic [1:0] i);
    uop_t u;
    logic [ADDR_W-1:0] ia;
    ia = {3'd0, i};
    unique case (off)
      5'd0: u = mk(OP_ACC0, A_K1 + ia, B_RAM,  A_K2 + ia, A_T0, i);
      5'd1: u = mk(OP_ACC1, A_K3 + ia, B_RAM,  A_K4 + ia, A_T0, i);
      5'd2: u = mk(OP_DIV,  A_T0,      B_RAM,  A_T0,      A_T0, i);
      5'd3: u = mk(OP_MULF, A_T0,      B_STEP, A_T0,      A_T0, i);
      5'd4: u = mk(OP_UPD,  A_P + ia,  B_RAM,  A_T0,      A_T0, i);
      default: u = mk(OP_LOAD, A_T2,   B_RAM,  A_T2,      A_T2, 2'd0);
    endcase
    return u;
  endfunction

  function automatic uop_t decode_uop(logic [SEG_W-1:0] seg, logic [OFF_W-1:0] off);
    uop_t u;
    unique case (seg)
      SEG_LOAD: u = mk(OP_LOAD, A_P, B_RAM, A_P, A_P + {3'd0, off[1:0]}, off[1:0]);
      SEG_D1:   u = deriv_uop(off, A_P,  A_K1);
      SEG_S1:   u = step_uop(off, A_K1, 1'b1);
      SEG_D2:   u = deriv_uop(off, A_PP, A_K2);
      SEG_S2:   u = step_uop(off, A_K2, 1'b1);
      SEG_D3:   u = deriv_uop(off, A_PP, A_K3);
      SEG_S3:   u = step_uop(off, A_K3, 1'b0);
      SEG_D4:   u = deriv_uop(off, A_PP, A_K4);
      SEG_F0:   u = final_uop(off, 2'd0);
      SEG_F1:   u = final_uop(off, 2'd1);
      SEG_F2:   u = final_uop(off, 2'd2);
      SEG_F3:   u = final_uop(off, 2'd3);
      default:  u = mk(OP_LOAD, A_T2, B_RAM, A_T2, A_T2, 2'd0);
    endcase
    return u;
  endfunction

  // Last offset of each segment
  function automatic logic [OFF_W-1:0] seg_last_off(logic [SEG_W-1:0] seg);
    logic [OFF_W-1:0] r;
    unique case (seg)
      SEG_LOAD:                       r = 5'd3;
      SEG_D1, SEG_D2, SEG_D3, SEG_D4: r = 5'd27;
      SEG_S1, SEG_S2, SEG_S3:         r = 5'd7;
      default:                        r = 5'd4;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rk4pp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rk4pp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/rk4pp_alu.sv
// Shared arithmetic unit: one registered multiplier, rounding, saturation, accumulator.
`default_nettype none
module rk4pp_alu #(
  parameter int FRAC_BITS = rk4pp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire rk4pp_pkg::alu_ctrl_t              ctrl_i,
  input  wire logic signed [31:0]                a_i,
  input  wire logic signed [31:0]                b_i,
  output logic signed [31:0]                     res_o,
  output logic signed [rk4pp_pkg::ACC_W-1:0]     acc_o
);

  localparam logic signed [64:0] HALF_F = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] HALF_H = 65'sd1 <<< FRAC_BITS;

  logic signed [31:0] a_q, b_q;
  logic signed [63:0] prod_q;
  logic signed [rk4pp_pkg::ACC_W-1:0] acc_q, acc_d, a_w, b_w;
  logic signed [64:0] prod_w, sh_f, sh_h, wide;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ex_en) begin
      a_q    <= a_i;
      b_q    <= b_i;
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.wb_en) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    prod_w = 65'(prod_q);
    sh_f   = (prod_w + HALF_F) >>> FRAC_BITS;
    sh_h   = (prod_w + HALF_H) >>> (FRAC_BITS + 1);
    a_w    = rk4pp_pkg::ACC_W'(a_q);
    b_w    = rk4pp_pkg::ACC_W'(b_q);
    acc_d  = acc_q;
    wide   = '0;
    unique case (ctrl_i.op)
      rk4pp_pkg::OP_MULF: wide = sh_f;
      rk4pp_pkg::OP_MULH: wide = sh_h;
      rk4pp_pkg::OP_ADD,
      rk4pp_pkg::OP_UPD:  wide = 65'(a_q) + 65'(b_q);
      rk4pp_pkg::OP_SUB:  wide = 65'(a_q) - 65'(b_q);
      rk4pp_pkg::OP_RSUB: wide = 65'(b_q) - 65'(a_q);
      rk4pp_pkg::OP_ACC0: acc_d = a_w + (b_w <<< 1);
      rk4pp_pkg::OP_ACC1: acc_d = acc_q + (a_w <<< 1) + b_w;
      default:            wide = '0;
    endcase
    res_o = rk4pp_pkg::sat32(wide);
    acc_o = acc_q;
  end

endmodule
`default_nettype wire

FILE: sv/rk4pp_div6.sv
// Floor((x + 3) / 6) for the RK4 weighted average, by reciprocal multiplication in two passes.
`default_nettype none
module rk4pp_div6 (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [rk4pp_pkg::ACC_W-1:0] x_i,
  output logic                                    done_o,
  output logic signed [31:0]                      q_o
);

  localparam int N  = rk4pp_pkg::ACC_W;
  localparam int ZW = 33;   // |x + 3| / 2 fits in 33 bits
  localparam int MW = 51;   // 17 x 34 bit partial product
  localparam int PW = 67;
  // ceil(2^35 / 3): floor(z * RECIP3 / 2^35) == floor(z / 3) for z < 2^35
  localparam logic [33:0] RECIP3 = 34'h2AAAAAAAB;

  logic              lo_q, hi_q, done_q, neg_q;
  logic [ZW-1:0]     z_q;
  logic [PW-1:0]     prod_q;
  logic [16:0]       mop;
  logic [MW-1:0]     pmul;
  logic [N-1:0]      mag;
  logic signed [N:0] xx;
  logic [31:0]       quo, qneg;

  always_comb begin
    xx   = (N+1)'(x_i) + (N+1)'(3);
    mag  = xx[N] ? N'(-xx + (N+1)'(5)) : N'(xx);
    // low half of z first, high half second
    mop  = lo_q ? {1'b0, z_q[15:0]} : z_q[32:16];
    pmul = {34'd0, mop} * {17'd0, RECIP3};
    quo  = prod_q[PW-1:35];
    qneg = 32'd0 - quo;
    q_o  = neg_q ? qneg : quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= 1'b0;
      hi_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      lo_q   <= start_i;
      hi_q   <= lo_q;
      done_q <= hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // floor(m / 6) == floor(floor(m / 2) / 3)
      z_q   <= mag[ZW:1];
      neg_q <= xx[N];
    end
    if (lo_q) begin
      prod_q <= PW'(pmul);
    end else if (hi_q) begin
      prod_q <= prod_q + {pmul, 16'd0};
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: sv/rk4_two_prey_predator_step_top.sv
// Top level: RK4 step of a two-predator, two-prey population model in fixed point.
//
// Usage notes:
// - Input channel (in_valid_i / in_stall_o / flip_year_i): one request is one time
//   step. flip_year_i toggles the good/harsh year before the step.
// - Output channel (out_valid_o / out_stall_i): one result per request, carrying
//   the four populations (Q8.24 by default), the year flag and the crash flag.
// - Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): ready is
//   always high; indexes 0..7 select the rate registers, others are dropped.
//   Write only while the block is idle.
// - Sequencing: a sequencer runs 160 micro-ops through one shared multiplier/adder,
//   each as scratch RAM read, multiply, write back; the four divide-by-six ops add
//   a wait on a two-pass reciprocal multiplier. The next request can be accepted
//   once the result reaches out_valid_o. Once crashed, an accepted request skips
//   the micro-ops and passes the frozen state straight to the output register.
// - Throughput: one request at a time; in_stall_o is high from accept until the
//   result is moved into the output register.
// - The output register holds a result while out_stall_i is high; the next step
//   may run meanwhile and waits at its end for the register to free up.
// - Reset: populations 0.5, 0.5, 0.6, 0.6, good year, no crash, rates at defaults.
`default_nettype none
module rk4_two_prey_predator_step_top #(
  parameter int FRAC_BITS = rk4pp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                flip_year_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [31:0]                       pop_sex_o,
  output logic signed [31:0]                       pop_asex_o,
  output logic signed [31:0]                       pop_prey_one_o,
  output logic signed [31:0]                       pop_prey_two_o,
  output logic                                     good_year_o,
  output logic                                     crashed_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rk4pp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rk4pp_pkg::CFG_W-1:0]         cfg_data_i
);

  // Fixed-point constants
  localparam logic signed [31:0] C_ONE    = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] C_Q25    = 32'(64'd1 << (FRAC_BITS - 2));
  localparam logic signed [31:0] C_Q50    = 32'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [31:0] POP_HALF = C_Q50;
  localparam logic signed [31:0] POP_SIX  =
    32'((64'd6 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  rk4pp_pkg::state_e state_q, state_d;
  logic [rk4pp_pkg::SEG_W-1:0] seg_q, seg_d;
  logic [rk4pp_pkg::OFF_W-1:0] off_q, off_d;
  rk4pp_pkg::uop_t  uop;

  logic [rk4pp_pkg::CFG_W-1:0] cfg_q [rk4pp_pkg::NUM_REGS];
  logic signed [31:0] pop_q [4];
  logic               year_q, crash_q;

  logic signed [31:0] out_pop_q [4];
  logic               out_year_q, out_crash_q, out_valid_q;

  logic               accept, ld_out, upd_en, ram_we, div_start, div_done;
  logic signed [31:0] rama_rdata, ramb_rdata, opb, alu_res, div_q, wdata;
  logic signed [rk4pp_pkg::ACC_W-1:0] acc;
  rk4pp_pkg::alu_ctrl_t alu_ctrl;

  assign uop         = rk4pp_pkg::decode_uop(seg_q, off_q);
  assign in_stall_o  = (state_q != rk4pp_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rk4pp_pkg::ST_IDLE;
      seg_q   <= '0;
      off_q   <= '0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      off_q   <= off_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    seg_d          = seg_q;
    off_d          = off_q;
    ld_out         = 1'b0;
    upd_en         = 1'b0;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    alu_ctrl.ex_en = 1'b0;
    alu_ctrl.wb_en = 1'b0;
    alu_ctrl.op    = uop.op;
    unique case (state_q)
      rk4pp_pkg::ST_IDLE: begin
        if (accept) begin
          seg_d   = rk4pp_pkg::SEG_LOAD;
          off_d   = '0;
          state_d = crash_q ? rk4pp_pkg::ST_FIN : rk4pp_pkg::ST_RD;
        end
      end
      rk4pp_pkg::ST_RD: state_d = rk4pp_pkg::ST_EX;
      rk4pp_pkg::ST_EX: begin
        alu_ctrl.ex_en = 1'b1;
        if (uop.op == rk4pp_pkg::OP_DIV) begin
          div_start = 1'b1;
          state_d   = rk4pp_pkg::ST_DIV;
        end else begin
          state_d = rk4pp_pkg::ST_WB;
        end
      end
      rk4pp_pkg::ST_DIV: begin
        if (div_done) state_d = rk4pp_pkg::ST_WB;
      end
      rk4pp_pkg::ST_WB: begin
        alu_ctrl.wb_en = 1'b1;
        upd_en = (uop.op == rk4pp_pkg::OP_UPD);
        ram_we = !((uop.op == rk4pp_pkg::OP_ACC0) || (uop.op == rk4pp_pkg::OP_ACC1) ||
                   (uop.op == rk4pp_pkg::OP_UPD));
        state_d = rk4pp_pkg::ST_RD;
        if (off_q == rk4pp_pkg::seg_last_off(seg_q)) begin
          off_d = '0;
          if (seg_q == rk4pp_pkg::SEG_LAST) state_d = rk4pp_pkg::ST_FIN;
          else seg_d = seg_q + 1'b1;
        end else begin
          off_d = off_q + 1'b1;
        end
      end
      rk4pp_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          ld_out  = 1'b1;
          state_d = rk4pp_pkg::ST_IDLE;
        end
      end
      default: state_d = rk4pp_pkg::ST_IDLE;
    endcase
  end

  // Operand B select: scratch RAM, rate registers or constants
  always_comb begin
    unique case (uop.bsrc)
      rk4pp_pkg::B_RAM:  opb = ramb_rdata;
      rk4pp_pkg::B_STEP: opb = {1'b0, cfg_q[rk4pp_pkg::REG_STEP]};
      rk4pp_pkg::B_BS:   opb = {1'b0, cfg_q[rk4pp_pkg::REG_BIRTH_SEX]};
      rk4pp_pkg::B_BA:   opb = {1'b0, cfg_q[rk4pp_pkg::REG_BIRTH_ASEX]};
      rk4pp_pkg::B_DS:   opb = {1'b0, cfg_q[rk4pp_pkg::REG_DEATH_SEX]};
      rk4pp_pkg::B_DA:   opb = {1'b0, cfg_q[rk4pp_pkg::REG_DEATH_ASEX]};
      rk4pp_pkg::B_GROW: opb = {1'b0, cfg_q[rk4pp_pkg::REG_GROWTH]};
      rk4pp_pkg::B_INVK: opb = year_q ? {1'b0, cfg_q[rk4pp_pkg::REG_INVK_GOOD]}
                                      : {1'b0, cfg_q[rk4pp_pkg::REG_INVK_HARSH]};
      rk4pp_pkg::B_ONE:  opb = C_ONE;
      rk4pp_pkg::B_Q25:  opb = C_Q25;
      rk4pp_pkg::B_Q50:  opb = C_Q50;
      default:           opb = ramb_rdata;
    endcase
  end

  // Write-back data
  always_comb begin
    unique case (uop.op)
      rk4pp_pkg::OP_LOAD: wdata = pop_q[uop.pidx];
      rk4pp_pkg::OP_DIV:  wdata = div_q;
      default:            wdata = alu_res;
    endcase
  end

  // Scratch RAM, duplicated for two read ports
  rk4pp_ram #(.WIDTH(32), .DEPTH(rk4pp_pkg::RAM_DEPTH)) u_rama (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (uop.d),
    .wdata_i (wdata),
    .raddr_i (uop.a),
    .rdata_o (rama_rdata)
  );

  rk4pp_ram #(.WIDTH(32), .DEPTH(rk4pp_pkg::RAM_DEPTH)) u_ramb (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (uop.d),
    .wdata_i (wdata),
    .raddr_i (uop.b),
    .rdata_o (ramb_rdata)
  );

  rk4pp_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i  (clk_i),
    .ctrl_i (alu_ctrl),
    .a_i    (rama_rdata),
    .b_i    (opb),
    .res_o  (alu_res),
    .acc_o  (acc)
  );

  rk4pp_div6 u_div6 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (acc),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Model state, rate registers, output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rk4pp_pkg::NUM_REGS; i++) cfg_q[i] <= rk4pp_pkg::CFG_RST[i];
      pop_q[0]    <= POP_HALF;
      pop_q[1]    <= POP_HALF;
      pop_q[2]    <= POP_SIX;
      pop_q[3]    <= POP_SIX;
      year_q      <= 1'b1;
      crash_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o &&
          (cfg_index_i < rk4pp_pkg::CFG_IDX_W'(rk4pp_pkg::NUM_REGS))) begin
        cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
      end
      // frozen after a crash, year flag included
      if (accept && !crash_q) year_q <= year_q ^ flip_year_i;
      if (upd_en) begin
        pop_q[uop.pidx] <= alu_res;
        if (alu_res[31]) crash_q <= 1'b1;
      end
      if (ld_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      for (int i = 0; i < 4; i++) out_pop_q[i] <= pop_q[i];
      out_year_q  <= year_q;
      out_crash_q <= crash_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pop_sex_o      = out_pop_q[0];
  assign pop_asex_o     = out_pop_q[1];
  assign pop_prey_one_o = out_pop_q[2];
  assign pop_prey_two_o = out_pop_q[3];
  assign good_year_o    = out_year_q;
  assign crashed_o      = out_crash_q;

endmodule
`default_nettype wire

FILE: sv/rk4pp_checker.sv
// Port-level checker for the RK4 predator-prey step block, with its bind.
`default_nettype none
module rk4pp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            flip_year_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic signed [31:0]              pop_sex_o,
  input wire logic signed [31:0]              pop_asex_o,
  input wire logic signed [31:0]              pop_prey_one_o,
  input wire logic signed [31:0]              pop_prey_two_o,
  input wire logic                            good_year_o,
  input wire logic                            crashed_o,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o,
  input wire logic [rk4pp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [rk4pp_pkg::CFG_W-1:0]     cfg_data_i
);

  // stalled result holds (valid, pop_sex, pop_prey_one and the crash flag)
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pop_sex_o) &&
    $stable(pop_prey_one_o) && $stable(crashed_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a request while busy");

  // crash flag is sticky
  a_crash_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crashed_o |=> crashed_o)
    else $error("crash flag cleared");

  // state frozen after crash
  a_crash_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crashed_o |=> $stable(pop_sex_o) && $stable(pop_asex_o) && $stable(pop_prey_one_o) &&
    $stable(pop_prey_two_o) && $stable(good_year_o))
    else $error("state changed after crash");

endmodule

bind rk4_two_prey_predator_step_top rk4pp_checker u_rk4pp_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the RK4 two-predator, two-prey step block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  // One step result as seen on the output channel
  typedef struct {
    logic signed [31:0] sex;
    logic signed [31:0] asex;
    logic signed [31:0] prey_one;
    logic signed [31:0] prey_two;
    logic               good;
    logic               crashed;
  } step_result_t;

  // Scoreboard: keeps its own copy of rates and populations, predicts each
  // step in fixed point and checks results in order.
  class pop_scoreboard;
    logic [rk4pp_pkg::CFG_W-1:0] rate [rk4pp_pkg::NUM_REGS];
    longint           pop [4];
    bit               good;
    bit               crashed;
    step_result_t     expected_q [$];
    int               errors;
    int               checked;
    int               requests;

    function new();
      for (int i = 0; i < rk4pp_pkg::NUM_REGS; i++) rate[i] = rk4pp_pkg::CFG_RST[i];
      pop[0] = longint'(1) << (rk4pp_pkg::FRAC_BITS_DEF - 1);
      pop[1] = longint'(1) << (rk4pp_pkg::FRAC_BITS_DEF - 1);
      pop[2] = (longint'(6) * (longint'(1) << rk4pp_pkg::FRAC_BITS_DEF) + 5) / 10;
      pop[3] = pop[2];
      good = 1'b1;
      crashed = 1'b0;
    endfunction

    function void set_rate(int idx, logic [rk4pp_pkg::CFG_W-1:0] val);
      if (idx < rk4pp_pkg::NUM_REGS) rate[idx] = val;
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // round to nearest, ties up, then saturate
    function longint rscale(longint x, int s);
      return sat((x + (longint'(1) << (s - 1))) >>> s);
    endfunction

    function longint fmul(longint a, longint b);
      return rscale(a * b, rk4pp_pkg::FRAC_BITS_DEF);
    endfunction

    function longint rt(int idx);
      return longint'(rate[idx]);
    endfunction

    function void slope(input longint v[4], input longint invk, output longint d[4]);
      longint one, q25, q50, food, eaten, grow, a;
      one = longint'(1) << rk4pp_pkg::FRAC_BITS_DEF;
      q25 = longint'(1) << (rk4pp_pkg::FRAC_BITS_DEF - 2);
      q50 = longint'(1) << (rk4pp_pkg::FRAC_BITS_DEF - 1);
      a = rt(rk4pp_pkg::REG_GROWTH);
      food = sat(fmul(v[3], q25) + fmul(v[2], q25));
      d[0] = sat(fmul(fmul(rt(rk4pp_pkg::REG_BIRTH_SEX), v[0]), food)
                 - fmul(rt(rk4pp_pkg::REG_DEATH_SEX), v[0]));
      food = sat(fmul(v[3], q50) + fmul(v[2], 0));
      d[1] = sat(fmul(fmul(rt(rk4pp_pkg::REG_BIRTH_ASEX), v[1]), food)
                 - fmul(rt(rk4pp_pkg::REG_DEATH_ASEX), v[1]));
      grow = fmul(fmul(a, v[2]), sat(one - fmul(v[2], invk)));
      eaten = fmul(v[2], sat(fmul(v[1], 0) + fmul(v[0], q25)));
      d[2] = sat(grow - eaten);
      grow = fmul(fmul(a, v[3]), sat(one - fmul(v[3], invk)));
      eaten = fmul(v[3], sat(fmul(v[1], q50) + fmul(v[0], q25)));
      d[3] = sat(grow - eaten);
    endfunction

    function longint div6(longint x);
      x += 3;
      if (x >= 0) return x / 6;
      return -((-x + 5) / 6);
    endfunction

    function void rk4_advance();
      longint pp[4], k1[4], k2[4], k3[4], k4[4];
      longint h, invk, sum, np;
      int     fb;
      fb = rk4pp_pkg::FRAC_BITS_DEF;
      h = rt(rk4pp_pkg::REG_STEP);
      invk = good ? rt(rk4pp_pkg::REG_INVK_GOOD) : rt(rk4pp_pkg::REG_INVK_HARSH);
      slope(pop, invk, k1);
      for (int i = 0; i < 4; i++) pp[i] = sat(pop[i] + rscale(k1[i] * h, fb + 1));
      slope(pp, invk, k2);
      for (int i = 0; i < 4; i++) pp[i] = sat(pop[i] + rscale(k2[i] * h, fb + 1));
      slope(pp, invk, k3);
      for (int i = 0; i < 4; i++) pp[i] = sat(pop[i] + rscale(k3[i] * h, fb));
      slope(pp, invk, k4);
      for (int i = 0; i < 4; i++) begin
        sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
        np = sat(pop[i] + fmul(div6(sum), h));
        if (np < 0) crashed = 1'b1;
        pop[i] = np;
      end
    endfunction

    function void note_request(bit flip);
      step_result_t r;
      requests++;
      if (!crashed) begin
        if (flip) good = !good;
        rk4_advance();
      end
      r.sex = 32'(pop[0]); r.asex = 32'(pop[1]);
      r.prey_one = 32'(pop[2]); r.prey_two = 32'(pop[3]);
      r.good = good; r.crashed = crashed;
      expected_q.push_back(r);
    endfunction

    function void check_result(step_result_t got);
      step_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.sex !== e.sex) begin
        $error("pop_sex: expected %0d, got %0d", e.sex, got.sex); errors++;
      end
      if (got.asex !== e.asex) begin
        $error("pop_asex: expected %0d, got %0d", e.asex, got.asex); errors++;
      end
      if (got.prey_one !== e.prey_one) begin
        $error("pop_prey_one: expected %0d, got %0d", e.prey_one, got.prey_one); errors++;
      end
      if (got.prey_two !== e.prey_two) begin
        $error("pop_prey_two: expected %0d, got %0d", e.prey_two, got.prey_two); errors++;
      end
      if (got.good !== e.good) begin
        $error("good_year: expected %0b, got %0b", e.good, got.good); errors++;
      end
      if (got.crashed !== e.crashed) begin
        $error("crashed: expected %0b, got %0b", e.crashed, got.crashed); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, flip_year_i;
  logic out_valid_o, out_stall_i;
  logic signed [31:0] pop_sex_o, pop_asex_o, pop_prey_one_o, pop_prey_two_o;
  logic good_year_o, crashed_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [rk4pp_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [rk4pp_pkg::CFG_W-1:0]     cfg_data_i;

  pop_scoreboard sb;
  int  hold_cycles;   // long receiver hold-off, counted down by the stall process
  bit  calm;          // no idling on either side while set
  int  cfg_writes;

  rk4_two_prey_predator_step_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .flip_year_i,
    .out_valid_o, .out_stall_i,
    .pop_sex_o, .pop_asex_o, .pop_prey_one_o, .pop_prey_two_o,
    .good_year_o, .crashed_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    step_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.sex = pop_sex_o; got.asex = pop_asex_o;
      got.prey_one = pop_prey_one_o; got.prey_two = pop_prey_two_o;
      got.good = good_year_o; got.crashed = crashed_o;
      sb.check_result(got);
    end
  end

  // Offer one step request; valid stays high into the next call when no gap follows
  task automatic send_step(bit flip);
    int g;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    flip_year_i <= flip;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(flip);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      flip_year_i <= 1'($urandom_range(0, 1));
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_step($urandom_range(0, 99) < 25);
  endtask

  // Wait for every pending result, then a short settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle
  task automatic cfg_write(int idx, logic [rk4pp_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[rk4pp_pkg::CFG_IDX_W-1:0];
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_rate(idx, val);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Every register scaled from its reset value by 75..125 percent
  task automatic cfg_perturb();
    longint v;
    for (int i = 0; i < rk4pp_pkg::NUM_REGS; i++) begin
      v = longint'(rk4pp_pkg::CFG_RST[i]) * $urandom_range(75, 125) / 100;
      cfg_write(i, v[rk4pp_pkg::CFG_W-1:0]);
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    flip_year_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    hold_cycles = 0;
    calm = 1'b0;
    cfg_writes = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed start at reset rates: steady years, single and back-to-back flips
    calm = 1'b1;
    send_step(1'b0); send_step(1'b0); send_step(1'b1);
    send_step(1'b1); send_step(1'b0); send_step(1'b1);
    calm = 1'b0;

    // Random steps at reset rates, including a long receiver hold-off
    send_random(300);
    hold_cycles = 3000;
    send_random(4);
    send_random(300);

    // Sender waits for all results, then new rates
    drain();
    cfg_perturb();
    send_random(300);
    calm = 1'b1;
    send_random(100);
    calm = 1'b0;

    // Indexes past the register file must be dropped
    drain();
    for (int i = rk4pp_pkg::NUM_REGS; i < (1 << rk4pp_pkg::CFG_IDX_W); i++) begin
      cfg_write(i, {rk4pp_pkg::CFG_W{1'b1}});
    end
    send_random(100);

    // All rates zero: populations must not move
    drain();
    for (int i = 0; i < rk4pp_pkg::NUM_REGS; i++) cfg_write(i, '0);
    send_step(1'b1); send_step(1'b0); send_step(1'b1);

    // Back to moderate rates for the bulk of the run
    drain();
    cfg_perturb();
    send_random(300);
    drain();
    cfg_perturb();
    send_random(450);

    // Top of range: saturation and, most likely, a crash that freezes the state
    drain();
    for (int i = 0; i < rk4pp_pkg::NUM_REGS; i++) cfg_write(i, {rk4pp_pkg::CFG_W{1'b1}});
    send_random(30);
    drain();
    cfg_write(rk4pp_pkg::REG_STEP, rk4pp_pkg::CFG_RST[rk4pp_pkg::REG_STEP]);
    send_random(10);

    drain();
    repeat (700) @(posedge clk_i);
    $display("Covered %0d step requests, %0d results checked, %0d register writes.",
             sb.requests, sb.checked, cfg_writes);
    $display("Rates: reset, scaled, zero and full scale; final crash flag %0b.",
             sb.crashed);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS rk4_two_prey_predator_step_top");
    end else begin
      $display("FAIL rk4_two_prey_predator_step_top");
    end
    $finish;
  end

  // Hard limit, several times the slowest correct run
  initial begin
    #250000000;
    $display("FAIL rk4_two_prey_predator_step_top");
    $finish;
  end

endmodule
`default_nettype wire
